### design/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled in reset
`define KH_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("kmer hash assertion failed");

// property that must never hold
`define KH_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("kmer hash forbidden condition");

`endif

### design/kh_pkg.sv
package kh_pkg;

  localparam int unsigned CODE_W   = 3;
  localparam int unsigned WIN_LEN  = 16;
  localparam int unsigned FILL_W   = 5;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned PFX_LEN  = 12;
  localparam int unsigned KEY_W    = 10;
  localparam int unsigned VAL_W    = 28;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned BITCNT_W = 5;

  localparam logic [CFG_W-1:0]   CFG_RESET  = 13'd4096;
  localparam logic [CHAR_W-1:0]  CH_FIRST   = 8'd65;
  localparam logic [CHAR_W-1:0]  CH_LAST    = 8'd90;
  localparam logic [CHAR_W-1:0]  CH_A       = 8'd65;
  localparam logic [CHAR_W-1:0]  CH_T       = 8'd84;
  localparam logic [CHAR_W-1:0]  CH_C       = 8'd67;
  localparam logic [CHAR_W-1:0]  CH_G       = 8'd71;
  localparam logic [CODE_W-1:0]  CODE_N     = 3'd0;
  localparam logic [CODE_W-1:0]  CODE_A     = 3'd1;
  localparam logic [CODE_W-1:0]  CODE_T     = 3'd2;
  localparam logic [CODE_W-1:0]  CODE_C     = 3'd3;
  localparam logic [CODE_W-1:0]  CODE_G     = 3'd4;
  localparam logic               MODE_INS   = 1'b0;
  localparam logic               MODE_SRCH  = 1'b1;
  localparam logic [IDX_W-1:0]   KEY_LOW    = 4'd12;
  localparam logic [IDX_W-1:0]   LAST_IDX   = 4'd15;
  localparam logic [FILL_W-1:0]  FULL_FILL  = 5'd16;
  localparam logic [BITCNT_W-1:0] TOP_BIT   = 5'd27;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_OCC_RD,
    ST_OCC_CHK,
    ST_KEY_RD,
    ST_KEY_CMP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic              mode;
    logic              restart;
    logic [CHAR_W-1:0] character;
  } in_t;

  typedef struct packed {
    logic             kind;
    logic             collision;
    logic             dropped;
    logic             match;
    logic [POS_W-1:0] window_start;
  } out_t;

  function automatic logic [CODE_W-1:0] letter_code(input logic [CHAR_W-1:0] ch);
    logic [CODE_W-1:0] c;
    case (ch)
      CH_A:    c = CODE_A;
      CH_T:    c = CODE_T;
      CH_C:    c = CODE_C;
      CH_G:    c = CODE_G;
      default: c = CODE_N;
    endcase
    return c;
  endfunction

endpackage

### design/kh_stream_if.sv
interface kh_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/kmer_hash_insert_and_search_top.sv
// a full window is hashed into a key and a bucket value, reduced by a restoring
//   remainder to a bucket, whose occupancy is read and checked; in search mode the
//   stored keys are then compared one by one (up to WAYS, stopping at a hit), and
//   the result waits for a free output register; input is held off meanwhile
// reset: async active low; a clearing pass empties every entry of the bucket
//   occupancy table before the first input transfer
module kmer_hash_insert_and_search_top #(
  parameter int unsigned BUCKETS = 4096,
  parameter int unsigned WAYS    = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [kh_pkg::CFG_W-1:0] cfg_wdata_i,
  kh_stream_if.sink              in_i,
  kh_stream_if.source            out_o
);
  import kh_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned OW  = $clog2(WAYS + 1);
  localparam int unsigned KAW = (BUCKETS * WAYS > 1) ? $clog2(BUCKETS * WAYS) : 1;
  localparam logic [BW-1:0] LAST_BKT = BW'(BUCKETS - 1);
  localparam logic [OW-1:0] WAYS_O   = OW'(WAYS);

  state_e state_q, state_d;

  logic [CFG_W-1:0]  cfg_q;
  logic [CFG_W-1:0]  nmod;
  logic [CODE_W-1:0] win_q [WIN_LEN];
  logic [CODE_W-1:0] win_d [WIN_LEN];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  start_q, start_d;
  logic              mode_q;
  logic              is_letter;
  logic              in_xfer;

  logic [IDX_W-1:0]    idx_q;
  logic [VAL_W-1:0]    acc_q, acc_n;
  logic [KEY_W-1:0]    key_q;
  logic [VAL_W-1:0]    val_q;
  logic [BITCNT_W-1:0] bit_q;
  logic [CFG_W-1:0]    rem_q;
  logic [CFG_W:0]      rem_t;
  logic [CFG_W-1:0]    rem_n;
  logic [BW-1:0]       bucket_q;
  logic [BW-1:0]       clr_q;

  logic [OW-1:0]    occ_mem [BUCKETS];
  logic [KEY_W-1:0] key_mem [BUCKETS * WAYS];
  logic [OW-1:0]    occ_rd_q;
  logic [OW-1:0]    occ;
  logic [KEY_W-1:0] key_rd_q;
  logic [OW-1:0]    sidx_q;
  logic             occ_we;
  logic [BW-1:0]    occ_waddr;
  logic [OW-1:0]    occ_wdata;
  logic             key_we;
  logic [KAW-1:0]   key_addr;
  logic             key_hit;
  logic             coll_q, drop_q, match_q;
  out_t             out_q;
  logic             out_vld_q;
  logic             out_load;

  // effective modulus
  always_comb begin
    if (cfg_q == '0) begin
      nmod = CFG_W'(1);
    end else if (32'(cfg_q) > 32'(BUCKETS)) begin
      nmod = CFG_W'(BUCKETS);
    end else begin
      nmod = cfg_q;
    end
  end

  assign is_letter = (in_i.data.character >= CH_FIRST) && (in_i.data.character <= CH_LAST);
  assign in_xfer   = in_i.valid && in_i.ready;

  // window update for one letter transfer
  always_comb begin
    logic [FILL_W-1:0] f;
    logic [POS_W-1:0]  p;
    f = in_i.data.restart ? '0 : fill_q;
    p = in_i.data.restart ? '0 : pos_q;
    for (int i = 0; i < WIN_LEN; i++) begin
      win_d[i] = in_i.data.restart ? CODE_N : win_q[i];
    end
    fill_d  = f;
    pos_d   = p;
    start_d = p - POS_W'(15);
    if (is_letter) begin
      if (f >= FULL_FILL) begin
        for (int i = 0; i < WIN_LEN - 1; i++) begin
          win_d[i] = win_d[i + 1];
        end
        win_d[WIN_LEN - 1] = letter_code(in_i.data.character);
        fill_d = FULL_FILL;
      end else begin
        win_d[f[IDX_W-1:0]] = letter_code(in_i.data.character);
        fill_d = f + FILL_W'(1);
      end
      pos_d = p + POS_W'(1);
    end
  end

  // shared multiply-by-five accumulate and restoring remainder step
  assign acc_n = (acc_q << 2) + acc_q + VAL_W'(win_q[idx_q]);
  assign rem_t = {rem_q, val_q[VAL_W-1]};
  assign rem_n = (rem_t >= {1'b0, nmod}) ? CFG_W'(rem_t - {1'b0, nmod}) : rem_t[CFG_W-1:0];

  assign occ      = (occ_rd_q > WAYS_O) ? WAYS_O : occ_rd_q;
  assign key_hit  = (key_rd_q == key_q);
  assign out_load = (state_q == ST_FINISH) && (!out_vld_q || out_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:   if (clr_q == LAST_BKT) state_d = ST_IDLE;
      ST_IDLE:    if (in_i.valid && is_letter && fill_d == FULL_FILL) state_d = ST_HASH;
      ST_HASH:    if (idx_q == '0) state_d = ST_MOD;
      ST_MOD:     if (bit_q == '0) state_d = ST_OCC_RD;
      ST_OCC_RD:  state_d = ST_OCC_CHK;
      ST_OCC_CHK: begin
        if (mode_q == MODE_INS || occ == '0) state_d = ST_FINISH;
        else state_d = ST_KEY_RD;
      end
      ST_KEY_RD:  state_d = ST_KEY_CMP;
      ST_KEY_CMP: begin
        if (key_hit || (sidx_q + OW'(1)) == occ) state_d = ST_FINISH;
        else state_d = ST_KEY_RD;
      end
      ST_FINISH:  if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_CLEAR;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    in_i.ready = 1'b0;
    occ_we     = 1'b0;
    occ_waddr  = bucket_q;
    occ_wdata  = occ + OW'(1);
    key_we     = 1'b0;
    key_addr   = KAW'(KAW'(bucket_q) * KAW'(WAYS)) + KAW'(sidx_q);
    case (state_q)
      ST_CLEAR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_q;
        occ_wdata = '0;
      end
      ST_IDLE: in_i.ready = 1'b1;
      ST_OCC_CHK: begin
        key_addr = KAW'(KAW'(bucket_q) * KAW'(WAYS)) + KAW'(occ);
        if (mode_q == MODE_INS && occ < WAYS_O) begin
          occ_we = 1'b1;
          key_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i) begin
    if (occ_we) occ_mem[occ_waddr] <= occ_wdata;
    occ_rd_q <= occ_mem[bucket_q];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_addr] <= key_q;
    key_rd_q <= key_mem[key_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cfg_q     <= CFG_RESET;
      fill_q    <= '0;
      pos_q     <= '0;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < WIN_LEN; i++) win_q[i] <= CODE_N;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (state_q == ST_CLEAR) clr_q <= clr_q + BW'(1);
      if (in_xfer) begin
        win_q  <= win_d;
        fill_q <= fill_d;
        pos_q  <= pos_d;
      end
      if (state_q == ST_OCC_CHK && mode_q == MODE_INS) fill_q <= '0;
      if (out_load) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        mode_q  <= in_i.data.mode;
        start_q <= start_d;
        idx_q   <= LAST_IDX;
        acc_q   <= '0;
      end
      ST_HASH: begin
        idx_q <= idx_q - IDX_W'(1);
        if (idx_q == KEY_LOW) begin
          key_q <= acc_n[KEY_W-1:0];
          acc_q <= '0;
        end else begin
          acc_q <= acc_n;
        end
        if (idx_q == '0) begin
          val_q <= acc_n;
          bit_q <= TOP_BIT;
          rem_q <= '0;
        end
      end
      ST_MOD: begin
        rem_q <= rem_n;
        val_q <= val_q << 1;
        bit_q <= bit_q - BITCNT_W'(1);
        if (bit_q == '0) bucket_q <= BW'(rem_n);
      end
      ST_OCC_CHK: begin
        sidx_q  <= '0;
        coll_q  <= (occ != '0);
        drop_q  <= (occ == WAYS_O);
        match_q <= 1'b0;
      end
      ST_KEY_CMP: begin
        sidx_q <= sidx_q + OW'(1);
        if (key_hit) match_q <= 1'b1;
      end
      ST_FINISH: begin
        if (out_load) begin
          out_q.kind <= mode_q;
          if (mode_q == MODE_INS) begin
            out_q.collision    <= coll_q;
            out_q.dropped      <= drop_q;
            out_q.match        <= 1'b0;
            out_q.window_start <= '0;
          end else begin
            out_q.collision    <= 1'b0;
            out_q.dropped      <= 1'b0;
            out_q.match        <= match_q;
            out_q.window_start <= start_q;
          end
        end
      end
      default: ;
    endcase
  end

  `KH_ASSERT(a_scan_in_range, clk_i, rst_ni, (state_q == ST_KEY_CMP) |-> (sidx_q < occ))
  `KH_ASSERT(a_drop_implies_coll, clk_i, rst_ni, (out_vld_q && out_q.dropped) |-> out_q.collision)
  `KH_NEVER(a_insert_no_match, clk_i, rst_ni, out_vld_q && !out_q.kind && out_q.match)
  `KH_ASSERT(a_clear_blocks_input, clk_i, rst_ni, (state_q == ST_CLEAR) |-> !in_i.ready)

endmodule

### test/kmer_hash_insert_and_search_top_test.sv
module kmer_hash_insert_and_search_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kh_pkg::*;

  localparam int unsigned NBUCKETS = 4096;
  localparam int unsigned NWAYS = 4;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  class kmer_scoreboard;
    logic [CODE_W-1:0] win[WIN_LEN];
    int unsigned fill;
    logic [POS_W-1:0] letter_pos;
    logic [CFG_W-1:0] nbuckets;
    logic [KEY_W-1:0] keys[NBUCKETS][NWAYS];
    int unsigned occ[NBUCKETS];
    out_t pending[$];
    int unsigned errors, inserts, searches, hits, drops;

    function void reset_state();
      foreach (win[i]) win[i] = CODE_N;
      foreach (occ[i]) occ[i] = 0;
      fill = 0;
      letter_pos = '0;
      nbuckets = CFG_RESET;
    endfunction

    function int unsigned base5(int unsigned first, int unsigned count);
      int unsigned v, w;
      v = 0;
      w = 1;
      for (int unsigned i = 0; i < count; i++) begin
        v += win[first + i] * w;
        w *= 5;
      end
      return v;
    endfunction

    function void note_input(in_t it);
      int unsigned n, bucket, key, o;
      logic [POS_W-1:0] p;
      out_t r;
      if (it.restart) begin
        foreach (win[i]) win[i] = CODE_N;
        fill = 0;
        letter_pos = '0;
      end
      if (it.character < CH_FIRST || it.character > CH_LAST) return;
      if (fill >= WIN_LEN) begin
        for (int i = 0; i < WIN_LEN - 1; i++) win[i] = win[i + 1];
        win[WIN_LEN - 1] = letter_code(it.character);
      end else begin
        win[fill] = letter_code(it.character);
        fill++;
      end
      p = letter_pos;
      letter_pos = letter_pos + 1;
      if (fill < WIN_LEN) return;
      n = nbuckets;
      if (n == 0) n = 1;
      if (n > NBUCKETS) n = NBUCKETS;
      bucket = base5(0, PFX_LEN) % n;
      key = base5(PFX_LEN, 4) & 10'h3ff;
      o = occ[bucket];
      r = '0;
      if (it.mode == MODE_INS) begin
        r.kind = MODE_INS;
        r.collision = (o > 0);
        if (o < NWAYS) begin
          keys[bucket][o] = KEY_W'(key);
          occ[bucket] = o + 1;
        end else begin
          r.dropped = 1'b1;
        end
        fill = 0;
      end else begin
        r.kind = MODE_SRCH;
        for (int unsigned i = 0; i < o; i++)
          if (keys[bucket][i] == key) r.match = 1'b1;
        r.window_start = p - 15;
      end
      pending.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.kind == MODE_INS) begin
        inserts++;
        if (got.dropped) drops++;
      end else begin
        searches++;
        if (got.match) hits++;
      end
      if (got.kind !== exp.kind) begin
        $display("%0t: kind exp %0d got %0d", $time, exp.kind, got.kind);
        errors++;
      end
      if (got.collision !== exp.collision) begin
        $display("%0t: collision exp %0d got %0d", $time, exp.collision, got.collision);
        errors++;
      end
      if (got.dropped !== exp.dropped) begin
        $display("%0t: dropped exp %0d got %0d", $time, exp.dropped, got.dropped);
        errors++;
      end
      if (got.match !== exp.match) begin
        $display("%0t: match exp %0d got %0d", $time, exp.match, got.match);
        errors++;
      end
      if (got.window_start !== exp.window_start) begin
        $display("%0t: window_start exp %0d got %0d", $time, exp.window_start,
                 got.window_start);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  int unsigned idle_cycles = 0;
  int unsigned stall_mode = 0;
  kmer_scoreboard sb;

  kh_stream_if #(.T(in_t)) in_if ();
  kh_stream_if #(.T(out_t)) out_if ();

  kmer_hash_insert_and_search_top #(.BUCKETS(NBUCKETS), .WAYS(NWAYS)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) sb.note_input(in_if.data);
    if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("timeout with %0d results pending", sb.pending.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stall pattern, changes character now and then
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= ($urandom_range(0, 1) == 0);
        default: out_if.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  int unsigned burst_left = 0;

  task automatic send_item(input logic mode, input logic restart, input logic [7:0] ch);
    in_t it;
    it.mode = mode;
    it.restart = restart;
    it.character = ch;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_bucket_count(input logic [CFG_W-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.nbuckets = v;
  endtask

  function automatic logic [7:0] rand_base();
    case ($urandom_range(0, 3))
      0: return CH_A;
      1: return CH_T;
      2: return CH_C;
      default: return CH_G;
    endcase
  endfunction

  function automatic logic [7:0] rand_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return rand_base();
    if (r < 90) return 8'($urandom_range(CH_FIRST, CH_LAST));
    return 8'($urandom_range(0, 255));
  endfunction

  // insert fragments drawn from a small pool so searches can hit them
  logic [7:0] pool[8][16];

  task automatic send_fragment(input logic mode, input int unsigned idx);
    for (int i = 0; i < 16; i++) send_item(mode, (i == 0), pool[idx][i]);
  endtask

  task automatic random_phase(input int unsigned items);
    int unsigned sent;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          send_fragment(MODE_INS, $urandom_range(0, 7));
          sent += 16;
        end
        3, 4: begin
          int unsigned p;
          p = $urandom_range(0, 7);
          send_item(MODE_SRCH, 1'b1, rand_base());
          for (int i = 0; i < 16; i++) send_item(MODE_SRCH, 1'b0, pool[p][i]);
          for (int i = 0; i < 4; i++) send_item(MODE_SRCH, 1'b0, rand_char());
          sent += 21;
        end
        default: begin
          send_item(1'($urandom_range(0, 1)), ($urandom_range(0, 30) == 0), rand_char());
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    logic [7:0] dir[$];
    sb = new();
    sb.reset_state();
    foreach (pool[i, j]) pool[i][j] = rand_base();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes of the byte, N letters, full bucket, mode switch, wrap of bytes
    dir = '{8'd0, 8'd255, 8'd64, 8'd91, CH_FIRST, CH_LAST, 8'd128, 8'd127};
    foreach (dir[i]) send_item(MODE_INS, 1'b0, dir[i]);
    for (int i = 0; i < 14; i++) send_item(MODE_INS, 1'b0, CH_G);
    for (int k = 0; k < 5; k++) send_fragment(MODE_INS, 0);
    send_item(MODE_SRCH, 1'b1, 8'h20);
    for (int i = 0; i < 17; i++) send_item(MODE_SRCH, 1'b0, pool[0][i % 16]);
    send_item(MODE_INS, 1'b0, CH_T);
    drain();
    send_fragment(MODE_INS, 1);
    send_fragment(MODE_SRCH, 1);
    // pause until all results are back
    drain();
    foreach (pool[i]) send_fragment(MODE_INS, i);
    random_phase(300);
    write_bucket_count(13'd0);
    random_phase(300);
    write_bucket_count(13'd1);
    random_phase(250);
    write_bucket_count(13'h1fff);
    random_phase(250);
    write_bucket_count(13'($urandom_range(2, 4095)));
    random_phase(300);
    drain();
    $display("inserts %0d (dropped %0d), searches %0d (matched %0d)",
             sb.inserts, sb.drops, sb.searches, sb.hits);
    $display("bucket counts 4096, 0, 1, 8191 and one random value exercised");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
